[rtl/sdft_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdft_pkg
// Shared constants, register codes and helper functions of the steepest
// descent flow tracer.
// ----------------------------------------------------------------------------
package sdft_pkg;

  localparam int ROW_BITS    = 6;
  localparam int COL_BITS    = 6;
  localparam int ADDR_BITS   = ROW_BITS + COL_BITS;
  localparam int STORE_DEPTH = 1 << ADDR_BITS;
  localparam int HEIGHT_BITS = 16;
  localparam int SCALE_BITS  = 16;
  localparam int PROD_BITS   = HEIGHT_BITS + SCALE_BITS;
  localparam int CFG_BITS    = 7;
  localparam int PADDR_BITS  = 4;
  localparam int PDATA_BITS  = 32;
  localparam int STEP_BITS   = 4;

  localparam logic [CFG_BITS-1:0]   MAX_ROWS    = 7'd64;
  localparam logic [CFG_BITS-1:0]   MAX_COLS    = 7'd64;
  localparam logic [CFG_BITS-1:0]   MIN_GRID    = 7'd3;
  localparam logic [CFG_BITS-1:0]   MAX_CAP     = 7'd64;
  localparam logic [CFG_BITS-1:0]   MIN_CAP     = 7'd1;
  localparam logic [SCALE_BITS-1:0] DIAG_SCALE  = 16'd62486;

  localparam logic [STEP_BITS-1:0]  LAST_ISSUE  = 4'd8;
  localparam logic [STEP_BITS-1:0]  LAST_STEP   = 4'd10;

  localparam logic [CFG_BITS-1:0]   OFF_MINUS   = 7'h7F;
  localparam logic [CFG_BITS-1:0]   OFF_ZERO    = 7'h00;
  localparam logic [CFG_BITS-1:0]   OFF_PLUS    = 7'h01;

  typedef enum logic [1:0] {
    REG_GRID_ROWS = 2'd0,
    REG_GRID_COLS = 2'd1,
    REG_MAX_PATH  = 2'd2
  } cfg_reg_t;

  function automatic logic [CFG_BITS-1:0] clamp_cfg(
    input logic [CFG_BITS-1:0] v,
    input logic [CFG_BITS-1:0] lo,
    input logic [CFG_BITS-1:0] hi
  );
    logic [CFG_BITS-1:0] r;
    if (v < lo) begin
      r = lo;
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // Step 0 reads the current cell, steps 1 to 8 its neighbours in row-major order.
  function automatic logic [CFG_BITS-1:0] nb_row_off(input logic [STEP_BITS-1:0] idx);
    logic [CFG_BITS-1:0] r;
    case (idx)
      4'd1, 4'd2, 4'd3: r = OFF_MINUS;
      4'd6, 4'd7, 4'd8: r = OFF_PLUS;
      default:          r = OFF_ZERO;
    endcase
    return r;
  endfunction

  function automatic logic [CFG_BITS-1:0] nb_col_off(input logic [STEP_BITS-1:0] idx);
    logic [CFG_BITS-1:0] r;
    case (idx)
      4'd1, 4'd4, 4'd6: r = OFF_MINUS;
      4'd3, 4'd5, 4'd8: r = OFF_PLUS;
      default:          r = OFF_ZERO;
    endcase
    return r;
  endfunction

  function automatic logic nb_is_diag(input logic [STEP_BITS-1:0] idx);
    logic r;
    case (idx)
      4'd1, 4'd3, 4'd6, 4'd8: r = 1'b1;
      default:                r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

[rtl/steepest_descent_flow_trace.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// steepest_descent_flow_trace
// Stores a height grid and traces steepest descent (D8) flow paths over it.
//
//   Channel   Direction  Handshake              Payload
//   in_       input      in_valid / in_stall    mode, cell_row, cell_col,
//                                               height, start_offset
//   out_      output     out_valid / out_stall  path_row, path_col, last,
//                                               truncated
//   APB       config     psel / penable / ...   grid_rows, grid_cols, max_path
//
// A load writes one entry of the height memory.
// For each path cell a trace makes nine reads of the single memory read port
// (the cell and its eight neighbours), passes them through two pipeline
// stages for the scaled drop and the compare, and ends in one decide state
// that emits the cell, where a stalled result register holds the trace.
// Reset is synchronous, clears control state and sets the config registers to
// their maxima; the height memory has no reset and no clearing pass.
// ----------------------------------------------------------------------------
module steepest_descent_flow_trace
  import sdft_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,

  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   in_mode,
  input  logic [ROW_BITS-1:0]    in_cell_row,
  input  logic [COL_BITS-1:0]    in_cell_col,
  input  logic [HEIGHT_BITS-1:0] in_height,
  input  logic [3:0]             in_start_offset,

  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [ROW_BITS-1:0]    out_path_row,
  output logic [COL_BITS-1:0]    out_path_col,
  output logic                   out_last,
  output logic                   out_truncated,

  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [PADDR_BITS-1:0]  paddr,
  input  logic [PDATA_BITS-1:0]  pwdata,
  output logic [PDATA_BITS-1:0]  prdata,
  output logic                   pready
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE
  } state_t;

  state_t                 state_r;
  logic [STEP_BITS-1:0]   step_r;
  logic [CFG_BITS-1:0]    grid_rows_r;
  logic [CFG_BITS-1:0]    grid_cols_r;
  logic [CFG_BITS-1:0]    max_path_r;
  logic [ROW_BITS-1:0]    walk_row_r;
  logic [COL_BITS-1:0]    walk_col_r;
  logic [CFG_BITS-1:0]    emit_cnt_r;
  logic [PROD_BITS-1:0]   best_drop_r;
  logic [ROW_BITS-1:0]    best_row_r;
  logic [COL_BITS-1:0]    best_col_r;
  logic                   found_r;

  logic                   out_valid_r;
  logic [ROW_BITS-1:0]    out_row_r;
  logic [COL_BITS-1:0]    out_col_r;
  logic                   out_last_r;
  logic                   out_trunc_r;

  logic                   s1_valid_r;
  logic                   s1_center_r;
  logic                   s1_ok_r;
  logic                   s1_diag_r;
  logic [ROW_BITS-1:0]    s1_row_r;
  logic [COL_BITS-1:0]    s1_col_r;
  logic [HEIGHT_BITS-1:0] here_r;

  logic                   s2_valid_r;
  logic                   s2_pos_r;
  logic [PROD_BITS-1:0]   s2_prod_r;
  logic [ROW_BITS-1:0]    s2_row_r;
  logic [COL_BITS-1:0]    s2_col_r;

  logic [HEIGHT_BITS-1:0] store_mem [STORE_DEPTH];
  logic [HEIGHT_BITS-1:0] rd_data_r;

  logic [CFG_BITS-1:0]    rows_c;
  logic [CFG_BITS-1:0]    cols_c;
  logic [CFG_BITS-1:0]    cap_c;
  logic [CFG_BITS-1:0]    start_sum;
  logic [CFG_BITS-1:0]    start_col;
  logic [CFG_BITS-1:0]    nb_row;
  logic [CFG_BITS-1:0]    nb_col;
  logic                   nb_in_grid;
  logic                   issue;
  logic [ADDR_BITS-1:0]   rd_addr;
  logic                   in_xfer;
  logic                   load_xfer;
  logic                   trace_xfer;
  logic                   cfg_write;
  logic                   out_free;
  logic                   stop_edge;
  logic                   stop_cap;
  logic [HEIGHT_BITS-1:0] drop;
  logic [PROD_BITS-1:0]   prod_nxt;
  logic [CFG_BITS-1:0]    emit_cnt_nxt;

  assign rows_c = clamp_cfg(grid_rows_r, MIN_GRID, MAX_ROWS);
  assign cols_c = clamp_cfg(grid_cols_r, MIN_GRID, MAX_COLS);
  assign cap_c  = clamp_cfg(max_path_r, MIN_CAP, MAX_CAP);

  assign start_sum = (cols_c >> 1) + {3'b000, in_start_offset};
  assign start_col = (start_sum > cols_c - 7'd1) ? cols_c - 7'd1 : start_sum;

  assign in_stall   = (state_r != S_IDLE);
  assign in_xfer    = in_valid && !in_stall;
  assign load_xfer  = in_xfer && !in_mode;
  assign trace_xfer = in_xfer && in_mode;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    case (cfg_reg_t'(paddr[3:2]))
      REG_GRID_ROWS: prdata = {{(PDATA_BITS-CFG_BITS){1'b0}}, grid_rows_r};
      REG_GRID_COLS: prdata = {{(PDATA_BITS-CFG_BITS){1'b0}}, grid_cols_r};
      REG_MAX_PATH:  prdata = {{(PDATA_BITS-CFG_BITS){1'b0}}, max_path_r};
      default:       prdata = '0;
    endcase
  end

  assign issue      = (state_r == S_SCAN) && (step_r <= LAST_ISSUE);
  assign nb_row     = {1'b0, walk_row_r} + nb_row_off(step_r);
  assign nb_col     = {1'b0, walk_col_r} + nb_col_off(step_r);
  assign nb_in_grid = (nb_row < rows_c) && (nb_col < cols_c);
  assign rd_addr    = {nb_row[ROW_BITS-1:0], nb_col[COL_BITS-1:0]};

  // Loads write only while idle and a trace only reads, so accesses never overlap.
  always_ff @(posedge clk) begin
    if (load_xfer) begin
      store_mem[{in_cell_row, in_cell_col}] <= in_height;
    end
    if (issue) begin
      rd_data_r <= store_mem[rd_addr];
    end
  end

  assign drop     = here_r - rd_data_r;
  assign prod_nxt = s1_diag_r ? PROD_BITS'(drop * DIAG_SCALE)
                              : {drop, {SCALE_BITS{1'b0}}};

  always_ff @(posedge clk) begin
    s1_center_r <= (step_r == '0);
    s1_ok_r     <= nb_in_grid;
    s1_diag_r   <= nb_is_diag(step_r);
    s1_row_r    <= nb_row[ROW_BITS-1:0];
    s1_col_r    <= nb_col[COL_BITS-1:0];
    if (s1_valid_r && s1_center_r) begin
      here_r <= rd_data_r;
    end
    s2_pos_r  <= s1_ok_r && (rd_data_r < here_r);
    s2_prod_r <= prod_nxt;
    s2_row_r  <= s1_row_r;
    s2_col_r  <= s1_col_r;
  end

  assign out_free     = !out_valid_r || !out_stall;
  assign stop_edge    = !found_r || ({1'b0, best_row_r} == rows_c - 7'd1) ||
                        ({1'b0, best_col_r} == cols_c - 7'd1) || (best_col_r == '0);
  assign stop_cap     = (emit_cnt_r >= cap_c);
  assign emit_cnt_nxt = emit_cnt_r + 7'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      grid_rows_r <= MAX_ROWS;
      grid_cols_r <= MAX_COLS;
      max_path_r  <= MAX_CAP;
      walk_row_r  <= '0;
      walk_col_r  <= '0;
      emit_cnt_r  <= '0;
      best_drop_r <= '0;
      best_row_r  <= '0;
      best_col_r  <= '0;
      found_r     <= 1'b0;
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      out_row_r   <= '0;
      out_col_r   <= '0;
      out_last_r  <= 1'b0;
      out_trunc_r <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_reg_t'(paddr[3:2]))
          REG_GRID_ROWS: grid_rows_r <= pwdata[CFG_BITS-1:0];
          REG_GRID_COLS: grid_cols_r <= pwdata[CFG_BITS-1:0];
          REG_MAX_PATH:  max_path_r  <= pwdata[CFG_BITS-1:0];
          default: ;
        endcase
      end

      s1_valid_r <= issue;
      s2_valid_r <= s1_valid_r && !s1_center_r;

      if (s2_valid_r && s2_pos_r && (s2_prod_r > best_drop_r)) begin
        best_drop_r <= s2_prod_r;
        best_row_r  <= s2_row_r;
        best_col_r  <= s2_col_r;
        found_r     <= 1'b1;
      end

      if (out_valid_r && !out_stall && (state_r != S_DECIDE)) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (trace_xfer) begin
            walk_row_r  <= '0;
            walk_col_r  <= start_col[COL_BITS-1:0];
            emit_cnt_r  <= 7'd1;
            step_r      <= '0;
            best_drop_r <= '0;
            found_r     <= 1'b0;
            state_r     <= S_SCAN;
          end
        end
        S_SCAN: begin
          step_r <= step_r + 4'd1;
          if (step_r == LAST_STEP) begin
            state_r <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_row_r   <= walk_row_r;
            out_col_r   <= walk_col_r;
            out_last_r  <= stop_edge || stop_cap;
            out_trunc_r <= !stop_edge && stop_cap;
            if (stop_edge || stop_cap) begin
              state_r <= S_IDLE;
            end else begin
              walk_row_r  <= best_row_r;
              walk_col_r  <= best_col_r;
              emit_cnt_r  <= emit_cnt_nxt;
              step_r      <= '0;
              best_drop_r <= '0;
              found_r     <= 1'b0;
              state_r     <= S_SCAN;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_path_row  = out_row_r;
  assign out_path_col  = out_col_r;
  assign out_last      = out_last_r;
  assign out_truncated = out_trunc_r;

`ifndef SYNTH
  a_trunc_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_trunc_r |-> out_last_r)
    else $error("truncated flag set on a cell that is not the last");

  a_cap_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> (emit_cnt_r <= cap_c) && (emit_cnt_r != '0))
    else $error("path cell count outside the cap");

  a_walk_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> ({1'b0, walk_col_r} < cols_c) && ({1'b0, walk_row_r} < rows_c))
    else $error("walk position outside the grid");

  a_trace_start: assert property (@(posedge clk) disable iff (!rst_n)
    trace_xfer |=> (state_r == S_SCAN) && (step_r == '0) && (walk_row_r == '0))
    else $error("trace transfer did not start a scan at row zero");

  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (step_r <= LAST_STEP))
    else $error("scan step counter overran");
`endif

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the steepest descent flow tracer. Load and trace
// commands stream in with random gaps while the result side stalls at random.
// Terrain is built lazily as traces are planned, so that no trace ever reads a
// height that was never loaded. Each emitted path cell is compared against an
// independent prediction made when its trace transfer is accepted. Grid size
// and path cap are swept over several settings through the APB port.
// ----------------------------------------------------------------------------
module testbench;
  import sdft_pkg::*;

  typedef enum logic {
    MODE_LOAD  = 1'b0,
    MODE_TRACE = 1'b1
  } mode_t;

  typedef struct {
    mode_t                  mode;
    logic [ROW_BITS-1:0]    row;
    logic [COL_BITS-1:0]    col;
    logic [HEIGHT_BITS-1:0] height;
    logic [3:0]             offset;
  } command_t;

  typedef struct {
    logic [ROW_BITS-1:0] row;
    logic [COL_BITS-1:0] col;
    logic                last;
    logic                truncated;
  } path_cell_t;

  localparam int PLAN         = 0;
  localparam int CHECK        = 1;
  localparam int ORTHO_WEIGHT = 65536;
  localparam int QUIET_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 30;
  localparam int PHASE_ITEMS  = 47;
  localparam int PHASE_MIN    = 3;
  localparam int ITEM_TARGET  = 420;
  localparam int NUM_PHASES   = 9;

  localparam int PHASE_ROWS   [NUM_PHASES] = '{10, 3, 0, 127, 64, 20, 7, 33, 0};
  localparam int PHASE_COLS   [NUM_PHASES] = '{12, 3, 0, 127, 64, 9, 40, 5, 0};
  localparam int PHASE_CAP    [NUM_PHASES] = '{5, 1, 0, 127, 64, 3, 64, 2, 0};
  localparam int PHASE_SLOPE  [NUM_PHASES] = '{300, 500, 50, 800, 400, 0, 900, 100, 0};
  localparam int PHASE_RIPPLE [NUM_PHASES] = '{400, 100, 200, 300, 2, 0, 1000, 3, 0};

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;

  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic                   in_mode = 1'b0;
  logic [ROW_BITS-1:0]    in_cell_row = '0;
  logic [COL_BITS-1:0]    in_cell_col = '0;
  logic [HEIGHT_BITS-1:0] in_height = '0;
  logic [3:0]             in_start_offset = '0;

  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [ROW_BITS-1:0]    out_path_row;
  logic [COL_BITS-1:0]    out_path_col;
  logic                   out_last;
  logic                   out_truncated;

  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [PADDR_BITS-1:0]  paddr = '0;
  logic [PDATA_BITS-1:0]  pwdata = '0;
  logic [PDATA_BITS-1:0]  prdata;
  logic                   pready;

  steepest_descent_flow_trace uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_mode         (in_mode),
    .in_cell_row     (in_cell_row),
    .in_cell_col     (in_cell_col),
    .in_height       (in_height),
    .in_start_offset (in_start_offset),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_path_row    (out_path_row),
    .out_path_col    (out_path_col),
    .out_last        (out_last),
    .out_truncated   (out_truncated),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  command_t               pending_items [$];
  path_cell_t             expected_path [$];
  logic [HEIGHT_BITS-1:0] height_mem [2][STORE_DEPTH];
  bit                     planned [STORE_DEPTH];
  logic [CFG_BITS-1:0]    cfg_value [3] = '{7'd64, 7'd64, 7'd64};
  int                     slope = 0;
  int                     ripple = 0;
  int                     errors = 0;
  int                     queued = 0;
  command_t               drv_item;
  int                     in_wait = 0;
  int                     out_wait = 0;
  bit                     in_calm = 1'b0;
  bit                     out_calm = 1'b0;
  int                     quiet = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int clamp_range(input int v, input int lo, input int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int used_rows();
    return clamp_range(int'(cfg_value[REG_GRID_ROWS]), 3, int'(MAX_ROWS));
  endfunction

  function automatic int used_cols();
    return clamp_range(int'(cfg_value[REG_GRID_COLS]), 3, int'(MAX_COLS));
  endfunction

  function automatic int used_cap();
    return clamp_range(int'(cfg_value[REG_MAX_PATH]), int'(MIN_CAP), int'(MAX_CAP));
  endfunction

  function automatic logic [HEIGHT_BITS-1:0] terrain(input int r);
    return HEIGHT_BITS'(clamp_range(60000 - r * slope + int'($urandom_range(0, ripple)),
                                    0, 65535));
  endfunction

  function automatic void queue_load(input int r, input int c,
                                     input logic [HEIGHT_BITS-1:0] h);
    command_t cmd;
    int       a;
    a = r * int'(MAX_COLS) + c;
    cmd.mode   = MODE_LOAD;
    cmd.row    = ROW_BITS'(r);
    cmd.col    = COL_BITS'(c);
    cmd.height = h;
    cmd.offset = 4'($urandom);
    height_mem[PLAN][a] = h;
    planned[a] = 1'b1;
    pending_items = {pending_items, cmd};
    queued++;
  endfunction

  // While planning, a height that has not been loaded yet is created here and
  // its load goes ahead of the trace that needs it.
  function automatic logic [HEIGHT_BITS-1:0] read_height(input int side, input int r,
                                                         input int c);
    int a;
    a = r * int'(MAX_COLS) + c;
    if (side == PLAN && !planned[a]) queue_load(r, c, terrain(r));
    return height_mem[side][a];
  endfunction

  function automatic void trace_path(input int side, input logic [3:0] offset);
    int                     rows, cols, cap, r, c, nr, nc, rr, cc, dr, dc, emitted;
    longint                 best, drop;
    logic [HEIGHT_BITS-1:0] here, nb;
    bit                     found, cut;
    path_cell_t             entry;
    rows = used_rows();
    cols = used_cols();
    cap  = used_cap();
    r = 0;
    c = clamp_range(cols / 2 + int'(offset), 0, cols - 1);
    emitted = 0;
    cut = 1'b0;
    forever begin
      if (side == CHECK) begin
        entry.row       = ROW_BITS'(r);
        entry.col       = COL_BITS'(c);
        entry.last      = 1'b0;
        entry.truncated = 1'b0;
        expected_path = {expected_path, entry};
      end
      emitted++;
      here = read_height(side, r, c);
      found = 1'b0;
      best = 0;
      nr = 0;
      nc = 0;
      for (dr = -1; dr <= 1; dr++) begin
        for (dc = -1; dc <= 1; dc++) begin
          rr = r + dr;
          cc = c + dc;
          if ((dr != 0 || dc != 0) && rr >= 0 && rr < rows && cc >= 0 && cc < cols) begin
            nb = read_height(side, rr, cc);
            if (nb < here) begin
              drop = longint'(here - nb) *
                     ((dr != 0 && dc != 0) ? longint'(DIAG_SCALE) : longint'(ORTHO_WEIGHT));
              if (drop > best) begin
                best = drop;
                nr = rr;
                nc = cc;
                found = 1'b1;
              end
            end
          end
        end
      end
      if (!found || nr == rows - 1 || nc == cols - 1 || nc == 0) break;
      if (emitted >= cap) begin
        cut = 1'b1;
        break;
      end
      r = nr;
      c = nc;
    end
    if (side == CHECK) begin
      expected_path[expected_path.size() - 1].last      = 1'b1;
      expected_path[expected_path.size() - 1].truncated = cut;
    end
  endfunction

  function automatic void queue_trace(input logic [3:0] offset);
    command_t cmd;
    trace_path(PLAN, offset);
    cmd.mode   = MODE_TRACE;
    cmd.row    = ROW_BITS'($urandom);
    cmd.col    = COL_BITS'($urandom);
    cmd.height = HEIGHT_BITS'($urandom);
    cmd.offset = offset;
    pending_items = {pending_items, cmd};
    queued++;
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $display("%0t %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  task automatic write_reg(input cfg_reg_t idx, input int value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= PDATA_BITS'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cfg_value[idx] = CFG_BITS'(value);
  endtask

  task automatic settle();
    while (pending_items.size() != 0 || in_valid || expected_path.size() != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        if (drv_item.mode == MODE_TRACE) begin
          trace_path(CHECK, drv_item.offset);
        end else begin
          height_mem[CHECK][{drv_item.row, drv_item.col}] = drv_item.height;
        end
      end
      if (!in_valid || !in_stall) begin
        if (in_wait > 0) begin
          in_wait--;
          in_valid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          drv_item = pending_items.pop_front();
          in_valid        <= 1'b1;
          in_mode         <= drv_item.mode;
          in_cell_row     <= drv_item.row;
          in_cell_col     <= drv_item.col;
          in_height       <= drv_item.height;
          in_start_offset <= drv_item.offset;
          if ($urandom_range(0, 19) == 0) in_calm = !in_calm;
          in_wait = in_calm ? 0 : int'($urandom_range(0, 3));
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : result_monitor
    path_cell_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_path.size() == 0) begin
          $display("%0t unexpected transfer: expected none, actual row %0d col %0d",
                   $time, out_path_row, out_path_col);
          errors++;
        end else begin
          want = expected_path.pop_front();
          check_field("path_row", 8'(want.row), 8'(out_path_row));
          check_field("path_col", 8'(want.col), 8'(out_path_col));
          check_field("last", 8'(want.last), 8'(out_last));
          check_field("truncated", 8'(want.truncated), 8'(out_truncated));
        end
        if ($urandom_range(0, 19) == 0) out_calm = !out_calm;
        out_wait = out_calm ? 0 : int'($urandom_range(0, 3));
      end
      if (out_wait > 0) begin
        out_stall <= 1'b1;
        out_wait--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin : stimulus
    int rows, cols, pick, rr, cc;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // A flat start gives a single cell path; then field extremes. Long
    // descents come with the full grid phases.
    queue_trace(4'd0);
    queue_load(0, 0, 16'h0000);
    queue_load(63, 63, 16'hFFFF);
    queue_load(0, 63, 16'hAAAA);
    queue_load(63, 0, 16'h5555);
    queue_trace(4'd15);

    // Each phase fills up to its share of the item total; a phase that follows
    // a costly one still gets at least PHASE_MIN items.
    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      if (p == NUM_PHASES - 1) begin
        write_reg(REG_GRID_ROWS, $urandom_range(0, 80));
        write_reg(REG_GRID_COLS, $urandom_range(0, 80));
        write_reg(REG_MAX_PATH, $urandom_range(0, 70));
        slope  = $urandom_range(0, 900);
        ripple = $urandom_range(0, 600);
      end else begin
        write_reg(REG_GRID_ROWS, PHASE_ROWS[p]);
        write_reg(REG_GRID_COLS, PHASE_COLS[p]);
        write_reg(REG_MAX_PATH, PHASE_CAP[p]);
        slope  = PHASE_SLOPE[p];
        ripple = PHASE_RIPPLE[p];
      end
      rows = used_rows();
      cols = used_cols();
      for (int n = 0; n < PHASE_ITEMS &&
           (n < PHASE_MIN || queued < (p + 1) * ITEM_TARGET / NUM_PHASES); n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          queue_trace(4'($urandom_range(0, 15)));
        end else if (pick < 85) begin
          rr = $urandom_range(0, rows - 1);
          cc = $urandom_range(0, cols - 1);
          queue_load(rr, cc, terrain(rr));
        end else begin
          queue_load($urandom_range(0, 63), $urandom_range(0, 63), 16'($urandom));
        end
      end
    end

    settle();
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
